// ----- rtl/blowfish_key1_cipher_unit_defines.svh -----
// Assertion macros shared by the cipher unit RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef BLOWFISH_KEY1_CIPHER_UNIT_DEFINES_SVH
`define BLOWFISH_KEY1_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bfk_pkg.sv -----
// Package of the cipher unit: key table layout, beat types and engine links.
// Depends on nothing.
`default_nettype none
package bfk_pkg;
  localparam int unsigned KEY_WORDS = 1042;
  localparam int unsigned AW = 11;

  localparam logic [AW-1:0] S0_BASE   = 11'h012;
  localparam logic [AW-1:0] S1_BASE   = 11'h112;
  localparam logic [AW-1:0] S2_BASE   = 11'h212;
  localparam logic [AW-1:0] S3_BASE   = 11'h312;
  localparam logic [AW-1:0] LAST_PAIR = 11'h410;
  localparam logic [4:0]    P_LAST    = 5'h11;
  localparam logic [4:0]    P_FIN     = 5'h10;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_INIT = 2'd1;
  localparam logic [1:0] OP_ENC  = 2'd2;
  localparam logic [1:0] OP_DEC  = 2'd3;

  localparam logic CFG_GAME_CODE = 1'b0;
  localparam logic CFG_MODULO    = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] table_index;
    logic [31:0] table_word;
    logic [63:0] block_in;
    logic [1:0]  key_level;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] block_out;
    logic        key_ready;
  } out_beat_t;

  typedef struct packed {
    logic        start;
    logic        dec;
    logic [63:0] block;
  } eng_cmd_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } eng_stat_t;
endpackage
`default_nettype wire

// ----- rtl/blowfish_key1_cipher_unit.sv -----
// Top level of the keyed 64-bit block cipher unit: sequencer, key RAMs, engine.
// Depends on bfk_pkg, bfk_ram, bfk_feistel and the shared assertion header.
//
// Usage. One input beat carries an op: load writes one initial key table
// word, init copies that table into the working key and runs the keycode
// schedule, encrypt and decrypt transform block_in with the working key.
// Every accepted beat yields exactly one result beat, in order; block_out
// is zero for load and init, key_ready shows that an init has finished.
// Throughput: one item at a time; a new beat is taken only once the last
// result has moved into the output register. A load goes straight to the
// response state. Encrypt or decrypt runs 16 rounds, each reading P and
// S-box words through the single read port of the working key RAM, then
// the final whitening reads and hand-off. Init copies the table, then per
// apply pass runs the keycode encryptions, P update and table regeneration.
// The result sits in an output register; the next input beat is accepted
// while it waits. If the receiver stalls and a second result is ready, the
// unit holds it and stalls its input until the output register frees.
// Reset clears the control state, the keycode words, key_ready and the
// configuration registers (game_code 0, keycode_modulo 8). The key tables
// are not cleared and must be loaded and initialized before use.
`default_nettype none
`include "blowfish_key1_cipher_unit_defines.svh"
module blowfish_key1_cipher_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  bfk_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output bfk_pkg::out_beat_t  out_data,
  input  wire                 cfg_we,
  input  wire                 cfg_index,
  input  wire  [31:0]         cfg_wdata
);
  import bfk_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_COPY  = 13'b0000000000010,
    S_NEXT  = 13'b0000000000100,
    S_KE1W  = 13'b0000000001000,
    S_KE2W  = 13'b0000000010000,
    S_XR    = 13'b0000000100000,
    S_XW    = 13'b0000001000000,
    S_RGW   = 13'b0000010000000,
    S_RGW1  = 13'b0000100000000,
    S_RGW2  = 13'b0001000000000,
    S_EWAIT = 13'b0010000000000,
    S_RESP  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] game_code_r;
  logic [3:0]  modulo_r;
  logic [31:0] kc0_r, kc0_nxt, kc1_r, kc1_nxt, kc2_r, kc2_nxt;
  logic        keyed_r, keyed_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [4:0]  off_r, off_nxt;
  logic [1:0]  pass_r, pass_nxt, level_r, level_nxt;
  logic        adj_r, adj_nxt;
  logic [63:0] blk_r, blk_nxt, res_r, res_nxt;
  logic        dec_r, dec_nxt, start_r, start_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_beat_t   out_data_r, out_data_nxt;

  logic          ini_we, wrk_we;
  logic [AW-1:0] ini_waddr, ini_raddr, wrk_waddr, wrk_raddr, eng_addr;
  logic [31:0]   ini_wdata, ini_rdata, wrk_wdata, wrk_rdata;
  eng_cmd_t      eng_cmd;
  eng_stat_t     eng_stat;
  logic          in_take;
  logic [95:0]   kc_vec;
  logic [31:0]   p_mask;
  logic          eng_wait;

  bfk_ram #(.WIDTH(32), .DEPTH(KEY_WORDS)) u_init_ram (
    .clk(clk), .we(ini_we), .waddr(ini_waddr), .wdata(ini_wdata),
    .raddr(ini_raddr), .rdata(ini_rdata)
  );

  bfk_ram #(.WIDTH(32), .DEPTH(KEY_WORDS)) u_work_ram (
    .clk(clk), .we(wrk_we), .waddr(wrk_waddr), .wdata(wrk_wdata),
    .raddr(wrk_raddr), .rdata(wrk_rdata)
  );

  assign eng_cmd.start = start_r;
  assign eng_cmd.dec   = dec_r;
  assign eng_cmd.block = blk_r;

  bfk_feistel u_feistel (
    .clk(clk), .rst_n(rst_n), .cmd(eng_cmd), .rd_data(wrk_rdata),
    .rd_addr(eng_addr), .stat(eng_stat)
  );

  // Next P offset: (off + 4) mod m, with off already below m.
  function automatic logic [4:0] mod_step(input logic [4:0] off, input logic [3:0] m);
    logic [4:0] v;
    v = off + 5'd4;
    for (int k = 0; k < 4; k++) begin
      if (v >= {1'b0, m}) v = v - {1'b0, m};
    end
    return (m == 4'd0) ? 5'd0 : v;
  endfunction

  // Keycode byte at position pos, which wraps modulo 12.
  function automatic logic [7:0] kc_byte(input logic [95:0] kv, input logic [4:0] pos);
    logic [4:0] p;
    p = (pos >= 5'd12) ? pos - 5'd12 : pos;
    return kv[p[3:0]*8 +: 8];
  endfunction

  assign kc_vec = {kc2_r, kc1_r, kc0_r};
  // Byte-swapped keycode word: the byte at the offset lands in the top byte.
  assign p_mask = {kc_byte(kc_vec, off_r), kc_byte(kc_vec, off_r + 5'd1),
                   kc_byte(kc_vec, off_r + 5'd2), kc_byte(kc_vec, off_r + 5'd3)};

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // The initial table is written by load beats and swept by the copy.
  assign ini_we    = in_take && (in_data.op == OP_LOAD) &&
                     (in_data.table_index < AW'(KEY_WORDS));
  assign ini_waddr = in_data.table_index;
  assign ini_wdata = in_data.table_word;
  assign ini_raddr = (cnt_r == AW'(KEY_WORDS)) ? '0 : cnt_r;

  assign wrk_raddr = (state_r == S_XR) ? cnt_r : eng_addr;

  always_comb begin
    wrk_we = 1'b0;
    wrk_waddr = cnt_r;
    wrk_wdata = ini_rdata;
    unique case (state_r)
      S_COPY: begin
        wrk_we = (cnt_r != '0);
        wrk_waddr = cnt_r - AW'(1);
      end
      S_XW: begin
        wrk_we = 1'b1;
        wrk_wdata = wrk_rdata ^ p_mask;
      end
      S_RGW1: begin
        wrk_we = 1'b1;
        wrk_wdata = blk_r[63:32];
      end
      S_RGW2: begin
        wrk_we = 1'b1;
        wrk_waddr = cnt_r + AW'(1);
        wrk_wdata = blk_r[31:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    kc0_nxt = kc0_r; kc1_nxt = kc1_r; kc2_nxt = kc2_r;
    keyed_nxt = keyed_r; cnt_nxt = cnt_r; off_nxt = off_r;
    pass_nxt = pass_r; level_nxt = level_r; adj_nxt = adj_r;
    blk_nxt = blk_r; res_nxt = res_r; dec_nxt = dec_r; start_nxt = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          res_nxt = '0;
          unique case (in_data.op)
            OP_LOAD: state_nxt = S_RESP;
            OP_INIT: begin
              cnt_nxt = '0;
              kc0_nxt = game_code_r;
              kc1_nxt = {1'b0, game_code_r[31:1]};
              kc2_nxt = {game_code_r[30:0], 1'b0};
              pass_nxt = 2'd0;
              adj_nxt = 1'b0;
              level_nxt = in_data.key_level;
              state_nxt = S_COPY;
            end
            OP_ENC, OP_DEC: begin
              blk_nxt = in_data.block_in;
              dec_nxt = (in_data.op == OP_DEC);
              start_nxt = 1'b1;
              state_nxt = S_EWAIT;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_COPY: begin
        if (cnt_r == AW'(KEY_WORDS)) begin
          state_nxt = S_NEXT;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_NEXT: begin
        // The keycode adjustment falls after the second pass or at the end.
        priority if (!adj_r && (pass_r == 2'd2 || pass_r >= level_r)) begin
          kc1_nxt = {kc1_r[30:0], 1'b0};
          kc2_nxt = {1'b0, kc2_r[31:1]};
          adj_nxt = 1'b1;
        end else if (pass_r < level_r) begin
          blk_nxt = {kc2_r, kc1_r};
          dec_nxt = 1'b0;
          start_nxt = 1'b1;
          state_nxt = S_KE1W;
        end else begin
          keyed_nxt = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_KE1W: begin
        if (eng_stat.done) begin
          kc1_nxt = eng_stat.result[31:0];
          kc2_nxt = eng_stat.result[63:32];
          blk_nxt = {eng_stat.result[31:0], kc0_r};
          start_nxt = 1'b1;
          state_nxt = S_KE2W;
        end
      end
      S_KE2W: begin
        if (eng_stat.done) begin
          kc0_nxt = eng_stat.result[31:0];
          kc1_nxt = eng_stat.result[63:32];
          cnt_nxt = '0;
          off_nxt = '0;
          state_nxt = S_XR;
        end
      end
      S_XR: state_nxt = S_XW;
      S_XW: begin
        off_nxt = mod_step(off_r, modulo_r);
        if (cnt_r == AW'(P_LAST)) begin
          cnt_nxt = '0;
          blk_nxt = '0;
          start_nxt = 1'b1;
          state_nxt = S_RGW;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
          state_nxt = S_XR;
        end
      end
      S_RGW: begin
        if (eng_stat.done) begin
          blk_nxt = eng_stat.result;
          state_nxt = S_RGW1;
        end
      end
      S_RGW1: state_nxt = S_RGW2;
      S_RGW2: begin
        if (cnt_r == LAST_PAIR) begin
          pass_nxt = pass_r + 2'd1;
          state_nxt = S_NEXT;
        end else begin
          cnt_nxt = cnt_r + AW'(2);
          start_nxt = 1'b1;
          state_nxt = S_RGW;
        end
      end
      S_EWAIT: begin
        if (eng_stat.done) begin
          res_nxt = eng_stat.result;
          state_nxt = S_RESP;
        end
      end
      S_FIN: state_nxt = S_RESP;
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.block_out = res_r;
          out_data_nxt.key_ready = keyed_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      game_code_r <= '0;
      modulo_r <= 4'd8;
      kc0_r <= '0; kc1_r <= '0; kc2_r <= '0;
      keyed_r <= 1'b0;
      start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kc0_r <= kc0_nxt; kc1_r <= kc1_nxt; kc2_r <= kc2_nxt;
      keyed_r <= keyed_nxt;
      start_r <= start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GAME_CODE: game_code_r <= cfg_wdata;
          CFG_MODULO:    modulo_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
    cnt_r <= cnt_nxt; off_r <= off_nxt; pass_r <= pass_nxt; level_r <= level_nxt;
    adj_r <= adj_nxt; blk_r <= blk_nxt; res_r <= res_nxt; dec_r <= dec_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The engine may only report a finished block while the sequencer waits on it.
  assign eng_wait = (state_r == S_EWAIT) || (state_r == S_KE1W) ||
                    (state_r == S_KE2W) || (state_r == S_RGW);

  `BFK_ASSERT_NEXT(a_busy_after_take, in_take, state_r != S_IDLE, "idle after accepting a beat")
  `BFK_ASSERT_NOW(a_done_when_waiting, eng_stat.done, eng_wait, "engine done outside a wait")
  `BFK_ASSERT_NOW(a_work_write_range, wrk_we, wrk_waddr < AW'(KEY_WORDS), "key write range")
endmodule
`default_nettype wire

// ----- rtl/bfk_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module bfk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/bfk_feistel.sv -----
// Round engine: runs 16 Feistel rounds reading P and S-box words one per cycle.
// Depends on bfk_pkg; reads the working key RAM through rd_addr / rd_data.
`default_nettype none
module bfk_feistel (
  input  wire                  clk,
  input  wire                  rst_n,
  input  bfk_pkg::eng_cmd_t    cmd,
  input  wire  [31:0]          rd_data,
  output logic [bfk_pkg::AW-1:0] rd_addr,
  output bfk_pkg::eng_stat_t   stat
);
  import bfk_pkg::*;

  typedef enum logic [8:0] {
    EP_IDLE  = 9'b000000001,
    EP_PADDR = 9'b000000010,
    EP_S0    = 9'b000000100,
    EP_S1    = 9'b000001000,
    EP_S2    = 9'b000010000,
    EP_S3    = 9'b000100000,
    EP_MIX   = 9'b001000000,
    EP_FIN1  = 9'b010000000,
    EP_FIN2  = 9'b100000000
  } eph_t;

  eph_t        ph_r, ph_nxt;
  logic [3:0]  rnd_r, rnd_nxt;
  logic        dec_r, dec_nxt;
  logic [31:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt, acc_r, acc_nxt, xo_r, xo_nxt;
  logic        done_r, done_nxt;
  logic [63:0] res_r, res_nxt;
  logic [31:0] z_now;

  function automatic logic [AW-1:0] p_addr(input logic dec, input logic [3:0] rnd);
    logic [4:0] idx;
    idx = dec ? (P_LAST - {1'b0, rnd}) : {1'b0, rnd};
    return {{(AW-5){1'b0}}, idx};
  endfunction

  assign z_now = rd_data ^ x_r;

  always_comb begin
    ph_nxt = ph_r; rnd_nxt = rnd_r; dec_nxt = dec_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; acc_nxt = acc_r; xo_nxt = xo_r;
    done_nxt = 1'b0; res_nxt = res_r;
    rd_addr = p_addr(dec_r, rnd_r);
    unique case (ph_r)
      EP_IDLE: begin
        if (cmd.start) begin
          dec_nxt = cmd.dec;
          x_nxt = cmd.block[63:32];
          y_nxt = cmd.block[31:0];
          rnd_nxt = 4'd0;
          ph_nxt = EP_PADDR;
        end
      end
      EP_PADDR: begin
        ph_nxt = EP_S0;
      end
      EP_S0: begin
        z_nxt = z_now;
        rd_addr = S0_BASE + {3'b0, z_now[31:24]};
        ph_nxt = EP_S1;
      end
      EP_S1: begin
        acc_nxt = rd_data;
        rd_addr = S1_BASE + {3'b0, z_r[23:16]};
        ph_nxt = EP_S2;
      end
      EP_S2: begin
        acc_nxt = acc_r + rd_data;
        rd_addr = S2_BASE + {3'b0, z_r[15:8]};
        ph_nxt = EP_S3;
      end
      EP_S3: begin
        acc_nxt = acc_r ^ rd_data;
        rd_addr = S3_BASE + {3'b0, z_r[7:0]};
        ph_nxt = EP_MIX;
      end
      EP_MIX: begin
        x_nxt = (acc_r + rd_data) ^ y_r;
        y_nxt = z_r;
        if (rnd_r == 4'd15) begin
          rd_addr = dec_r ? {{(AW-1){1'b0}}, 1'b1} : {{(AW-5){1'b0}}, P_FIN};
          ph_nxt = EP_FIN1;
        end else begin
          rnd_nxt = rnd_r + 4'd1;
          rd_addr = p_addr(dec_r, rnd_r + 4'd1);
          ph_nxt = EP_S0;
        end
      end
      EP_FIN1: begin
        xo_nxt = x_r ^ rd_data;
        rd_addr = dec_r ? '0 : {{(AW-5){1'b0}}, P_LAST};
        ph_nxt = EP_FIN2;
      end
      EP_FIN2: begin
        res_nxt = {y_r ^ rd_data, xo_r};
        done_nxt = 1'b1;
        ph_nxt = EP_IDLE;
      end
      default: ph_nxt = EP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= EP_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      done_r <= done_nxt;
    end
    rnd_r <= rnd_nxt; dec_r <= dec_nxt;
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; acc_r <= acc_nxt; xo_r <= xo_nxt;
    res_r <= res_nxt;
  end

  assign stat.done = done_r;
  assign stat.result = res_r;
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the Blowfish-style cipher unit.
// Depends on bfk_pkg and blowfish_key1_cipher_unit. Items are predicted by
// an in-bench copy of the key schedule and the Feistel rounds.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import bfk_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  logic      cfg_we;
  logic      cfg_index;
  logic [31:0] cfg_wdata;

  blowfish_key1_cipher_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Our own copy of the unit's state, advanced once per accepted beat.
  logic [31:0] init_tab [KEY_WORDS];
  logic [31:0] work_tab [KEY_WORDS];
  logic [31:0] keycode [3];
  logic        keyed;
  logic [31:0] game_code;
  logic [3:0]  kc_modulo;

  // Results we are still waiting for, oldest first.
  out_beat_t pending_results[$];
  int unsigned mismatches;

  // Shared knobs between the stimulus and the receiver process.
  bit gaps_on;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run time of the whole test.
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Cipher predictor
  // ---------------------------------------------------------------------

  // The S-box mix of one round, read from the working key.
  function automatic logic [31:0] sbox_f(logic [31:0] z);
    logic [31:0] x;
    x = work_tab[S0_BASE + z[31:24]];
    x = x + work_tab[S1_BASE + z[23:16]];
    x = x ^ work_tab[S2_BASE + z[15:8]];
    x = x + work_tab[S3_BASE + z[7:0]];
    return x;
  endfunction

  function automatic logic [63:0] encipher(logic [63:0] b);
    logic [31:0] x, y, z;
    y = b[31:0];
    x = b[63:32];
    for (int r = 0; r < 16; r++) begin
      z = work_tab[r] ^ x;
      x = sbox_f(z) ^ y;
      y = z;
    end
    return {y ^ work_tab[P_LAST], x ^ work_tab[P_FIN]};
  endfunction

  // Decryption walks the P words from the top down to word 2.
  function automatic logic [63:0] decipher(logic [63:0] b);
    logic [31:0] x, y, z;
    y = b[31:0];
    x = b[63:32];
    for (int r = 17; r >= 2; r--) begin
      z = work_tab[r] ^ x;
      x = sbox_f(z) ^ y;
      y = z;
    end
    return {y ^ work_tab[0], x ^ work_tab[1]};
  endfunction

  // Keycode bytes are addressed modulo twelve, little-endian inside a word.
  function automatic logic [7:0] keycode_byte(int unsigned pos);
    int unsigned p;
    p = pos % 12;
    return 8'(keycode[p >> 2] >> (8 * (p & 3)));
  endfunction

  // One apply pass: encrypt the keycode, fold it into P, regenerate the key.
  task automatic apply_pass();
    logic [63:0] b;
    logic [31:0] w;
    int unsigned off;
    b = encipher({keycode[2], keycode[1]});
    keycode[1] = b[31:0];
    keycode[2] = b[63:32];
    b = encipher({keycode[1], keycode[0]});
    keycode[0] = b[31:0];
    keycode[1] = b[63:32];
    for (int unsigned i = 0; i <= P_LAST; i++) begin
      off = (kc_modulo == 0) ? 0 : (i * 4) % kc_modulo;
      // The little-endian word is byte-swapped before the XOR, so the
      // first keycode byte lands in the top byte.
      w = {keycode_byte(off), keycode_byte(off + 1),
           keycode_byte(off + 2), keycode_byte(off + 3)};
      work_tab[i] = work_tab[i] ^ w;
    end
    b = '0;
    for (int unsigned i = 0; i <= LAST_PAIR; i += 2) begin
      b = encipher(b);
      work_tab[i]     = b[63:32];
      work_tab[i + 1] = b[31:0];
    end
  endtask

  task automatic key_schedule(logic [1:0] level);
    work_tab = init_tab;
    keycode[0] = game_code;
    keycode[1] = game_code >> 1;
    keycode[2] = game_code << 1;
    if (level >= 1) apply_pass();
    if (level >= 2) apply_pass();
    keycode[1] = keycode[1] << 1;
    keycode[2] = keycode[2] >> 1;
    if (level >= 3) apply_pass();
    keyed = 1'b1;
  endtask

  task automatic cipher_predict(in_beat_t b, output out_beat_t r);
    r.block_out = '0;
    case (b.op)
      OP_LOAD: begin
        if (b.table_index < KEY_WORDS) init_tab[b.table_index] = b.table_word;
      end
      OP_INIT: key_schedule(b.key_level);
      OP_ENC:  r.block_out = encipher(b.block_in);
      default: r.block_out = decipher(b.block_in);
    endcase
    r.key_ready = keyed;
  endtask

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offers one beat, waits for it to be taken, then records what must come
  // back. A typed-in expectation replaces the predicted one when given.
  task automatic send_beat(in_beat_t b, bit typed = 1'b0, out_beat_t typed_res = '0);
    out_beat_t r;
    if (gaps_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cipher_predict(b, r);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // Registers only change once the unit has drained; the spare wait cycles
  // cover the hand-off from the output register.
  task automatic write_reg(logic idx, logic [31:0] val);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GAME_CODE) game_code = val;
    else kc_modulo = val[3:0];
  endtask

  function automatic in_beat_t random_beat();
    in_beat_t b;
    int unsigned pick;
    b.table_word  = $urandom;
    b.key_level   = 2'($urandom_range(3));
    b.block_in    = {$urandom, $urandom};
    b.table_index = 11'($urandom_range(KEY_WORDS - 1));
    pick = $urandom_range(99);
    if (pick < 10) begin
      b.op = OP_LOAD;
      // Some loads aim past the table and must be ignored.
      if ($urandom_range(4) == 0) b.table_index = 11'($urandom_range(2047, KEY_WORDS));
    end else if (pick < 55) begin
      b.op = OP_ENC;
    end else begin
      b.op = OP_DEC;
    end
    if ($urandom_range(19) == 0) b.block_in = '1;
    else if ($urandom_range(19) == 0) b.block_in = '0;
    return b;
  endfunction

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t res;
  } stim_row_t;

  function automatic stim_row_t row(logic [1:0] op, logic [10:0] idx, logic [31:0] word,
                                    logic [63:0] blk, logic [1:0] lvl,
                                    bit typed, out_beat_t res);
    stim_row_t s;
    s.beat  = '{op: op, table_index: idx, table_word: word, block_in: blk, key_level: lvl};
    s.typed = typed;
    s.res   = res;
    return s;
  endfunction

  // Settings swept between random phases: game code, modulo, init depth.
  // Modulo zero, odd values and values above twelve are all legal encodings.
  typedef struct {
    logic [31:0] gc;
    logic [3:0]  md;
    logic [1:0]  lvl;
  } phase_cfg_t;

  initial begin
    stim_row_t   dir_rows[$];
    phase_cfg_t  phases[5];
    in_beat_t    b;
    out_beat_t   zero_res;
    out_beat_t   ready_res;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_GAME_CODE;
    cfg_wdata = '0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    mismatches = 0;
    keyed = 1'b0;
    game_code = '0;
    kc_modulo = 4'd8;
    for (int i = 0; i < 3; i++) keycode[i] = '0;
    for (int i = 0; i < KEY_WORDS; i++) begin
      init_tab[i] = '0;
      work_tab[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    zero_res  = '{block_out: '0, key_ready: 1'b0};
    ready_res = '{block_out: '0, key_ready: 1'b1};

    // Fill the whole initial table first so no later read hits an
    // unwritten entry.
    for (int i = 0; i < KEY_WORDS; i++) begin
      b = '{op: OP_LOAD, table_index: 11'(i), table_word: $urandom,
            block_in: {$urandom, $urandom}, key_level: 2'($urandom_range(3))};
      send_beat(b, 1'b1, zero_res);
    end

    // Directed beats: table edges, ignored indexes, every op, block extremes.
    dir_rows.push_back(row(OP_LOAD, 11'd0, 32'h0, '0, 2'd0, 1'b1, zero_res));
    dir_rows.push_back(row(OP_LOAD, 11'd1041, '1, '1, 2'd3, 1'b1, zero_res));
    dir_rows.push_back(row(OP_LOAD, 11'd1042, 32'hDEADBEEF, '0, 2'd0, 1'b1, zero_res));
    dir_rows.push_back(row(OP_LOAD, 11'd2047, '1, '0, 2'd0, 1'b1, zero_res));
    dir_rows.push_back(row(OP_INIT, 11'd0, '0, '0, 2'd0, 1'b1, ready_res));
    dir_rows.push_back(row(OP_ENC, 11'd0, '0, '0, 2'd0, 1'b0, zero_res));
    dir_rows.push_back(row(OP_ENC, '1, '1, '1, 2'd3, 1'b0, zero_res));
    dir_rows.push_back(row(OP_DEC, 11'd0, '0, '0, 2'd0, 1'b0, zero_res));
    dir_rows.push_back(row(OP_DEC, '1, '1, '1, 2'd3, 1'b0, zero_res));
    dir_rows.push_back(row(OP_ENC, 11'd5, 32'h1, 64'h0123_4567_89AB_CDEF, 2'd1, 1'b0,
                           zero_res));
    dir_rows.push_back(row(OP_DEC, 11'd5, 32'h1, 64'h0123_4567_89AB_CDEF, 2'd2, 1'b0,
                           zero_res));
    dir_rows.push_back(row(OP_LOAD, 11'd17, 32'h8000_0001, '0, 2'd0, 1'b1, ready_res));
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].res);

    phases[0] = '{gc: $urandom, md: 4'd4,  lvl: 2'd1};
    phases[1] = '{gc: '1,       md: 4'd12, lvl: 2'd2};
    phases[2] = '{gc: $urandom, md: 4'd0,  lvl: 2'd3};
    phases[3] = '{gc: $urandom, md: 4'd15, lvl: 2'd1};
    phases[4] = '{gc: $urandom, md: 4'd5,  lvl: 2'd2};

    foreach (phases[p]) begin
      // Writing the registers also drains the unit, which is the sender's
      // pause until every outstanding result has come back.
      write_reg(CFG_GAME_CODE, phases[p].gc);
      write_reg(CFG_MODULO, {28'd0, phases[p].md});
      b = random_beat();
      b.op = OP_INIT;
      b.key_level = phases[p].lvl;
      send_beat(b);
      for (int n = 0; n < 90; n++) begin
        // Phase one holds the receiver off for a long stretch mid-way;
        // phase two starts with a stretch of back-to-back traffic.
        if (p == 0 && n == 40) hold_req = 1'b1;
        gaps_on = !(p == 1 && n < 45);
        send_beat(random_beat());
      end
    end
    in_valid <= 1'b0;
    gaps_on = 1'b1;

    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------

  // Random stall, or a long counted hold-off when the stimulus asks for it.
  // The sender keeps offering beats during the hold-off, so the unit fills
  // and has to stall its input.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 33);
      end
    end
  end

  // Every result beat is matched against the oldest expectation.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: block %h ready %b",
                   out_data.block_out, out_data.key_ready);
      end else begin
        want = pending_results.pop_front();
        if (out_data.block_out !== want.block_out ||
            out_data.key_ready !== want.key_ready) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: block exp %h got %h, ready exp %b got %b",
                     want.block_out, out_data.block_out,
                     want.key_ready, out_data.key_ready);
        end
      end
    end
  end
endmodule
`default_nettype wire
